/* rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the shell line tokeniser
// Character codes, beat payload types and the queue entry passed between the
// front and back parts.
// ----------------------------------------------------------------------------
package slt_pkg;

  // special characters
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_PIPE      = 8'h7C;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_LT        = 8'h3C;

  // quote state codes
  localparam logic [1:0] QK_NONE   = 2'd0;
  localparam logic [1:0] QK_SINGLE = 2'd1;
  localparam logic [1:0] QK_DOUBLE = 2'd2;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  // default depth of the entry queue
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
  } item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_out;
    logic       token_end;
    logic       line_done;
    logic       last;
  } result_t;

  // one item's worth of results: one or two beats
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

/* rtl/slt_front.sv */
// ----------------------------------------------------------------------------
// slt_front: item classifier
// Holds the tokeniser state, takes one item per cycle while the queue is not
// full and turns it into an entry of one or two result beats for the queue.
// Items that give no result only update the state.
// ----------------------------------------------------------------------------
module slt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  slt_pkg::item_t   item,
  input  logic             q_full,
  output logic             q_push,
  output slt_pkg::entry_t  q_entry
);

  logic [1:0] quote_kind, quote_kind_next;
  logic       escape_pending, escape_pending_next;
  logic       token_open, token_open_next;
  logic       token_has_chars, token_has_chars_next;
  logic       in_comment, in_comment_next;
  logic       redirect_pending, redirect_pending_next;

  logic             accept;
  logic [1:0]       n;
  logic             skip;
  logic [7:0]       c;
  logic [7:0]       closer;
  slt_pkg::result_t res [2];
  slt_pkg::result_t close_beat;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign close_beat = '{has_char: 1'b0, char_out: 8'h00, token_end: 1'b1,
                        line_done: 1'b0, last: 1'b0};

  // classify the item and work out the next state
  always_comb begin
    quote_kind_next       = quote_kind;
    escape_pending_next   = escape_pending;
    token_open_next       = token_open;
    token_has_chars_next  = token_has_chars;
    in_comment_next       = in_comment;
    redirect_pending_next = redirect_pending;
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    skip   = 1'b0;
    c      = item.byte_in;
    closer = (quote_kind == slt_pkg::QK_SINGLE) ? slt_pkg::CH_SQUOTE : slt_pkg::CH_DQUOTE;

    if (item.command == slt_pkg::CMD_EOL) begin
      // end of line: one beat, then everything back to reset
      res[0] = '{has_char: 1'b0, char_out: 8'h00, token_end: token_open,
                 line_done: 1'b1, last: 1'b1};
      n = 2'd1;
      quote_kind_next       = slt_pkg::QK_NONE;
      escape_pending_next   = 1'b0;
      token_open_next       = 1'b0;
      token_has_chars_next  = 1'b0;
      in_comment_next       = 1'b0;
      redirect_pending_next = 1'b0;
    end else if (!in_comment) begin
      // a lone '>' is waiting: either make '>>' or close it
      if (redirect_pending) begin
        redirect_pending_next = 1'b0;
        token_open_next       = 1'b0;
        token_has_chars_next  = 1'b0;
        n = 2'd1;
        if (c == slt_pkg::CH_GT) begin
          res[0] = '{has_char: 1'b1, char_out: slt_pkg::CH_GT, token_end: 1'b1,
                     line_done: 1'b0, last: 1'b0};
          skip   = 1'b1;
        end else begin
          res[0] = close_beat;
        end
      end

      if (!skip) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          res[n[0]] = '{has_char: 1'b1, char_out: c, token_end: 1'b0,
                        line_done: 1'b0, last: 1'b0};
          n = n + 2'd1;
          token_open_next      = 1'b1;
          token_has_chars_next = 1'b1;
        end else if (c == slt_pkg::CH_BACKSLASH) begin
          escape_pending_next = 1'b1;
        end else if ((c == slt_pkg::CH_DQUOTE || c == slt_pkg::CH_SQUOTE) &&
                     quote_kind == slt_pkg::QK_NONE) begin
          // opening quote: end a word in progress, open an empty token
          if (token_has_chars_next) begin
            res[n[0]] = close_beat;
            n = n + 2'd1;
          end
          quote_kind_next = (c == slt_pkg::CH_SQUOTE) ? slt_pkg::QK_SINGLE
                                                      : slt_pkg::QK_DOUBLE;
          token_open_next      = 1'b1;
          token_has_chars_next = 1'b0;
        end else if (quote_kind != slt_pkg::QK_NONE) begin
          if (c == closer) begin
            quote_kind_next = slt_pkg::QK_NONE;
            res[n[0]] = close_beat;
            n = n + 2'd1;
            token_open_next      = 1'b0;
            token_has_chars_next = 1'b0;
          end else begin
            res[n[0]] = '{has_char: 1'b1, char_out: c, token_end: 1'b0,
                          line_done: 1'b0, last: 1'b0};
            n = n + 2'd1;
            token_open_next      = 1'b1;
            token_has_chars_next = 1'b1;
          end
        end else if (c == slt_pkg::CH_SPACE) begin
          if (token_has_chars_next) begin
            res[n[0]] = close_beat;
            n = n + 2'd1;
            token_open_next      = 1'b0;
            token_has_chars_next = 1'b0;
          end
        end else if (c == slt_pkg::CH_HASH) begin
          in_comment_next = 1'b1;
        end else if (c == slt_pkg::CH_PIPE || c == slt_pkg::CH_LT ||
                     c == slt_pkg::CH_GT) begin
          // operator: close a word in progress first
          if (token_has_chars_next) begin
            res[n[0]] = close_beat;
            n = n + 2'd1;
          end
          if (c == slt_pkg::CH_GT) begin
            res[n[0]] = '{has_char: 1'b1, char_out: c, token_end: 1'b0,
                          line_done: 1'b0, last: 1'b0};
            token_open_next       = 1'b1;
            token_has_chars_next  = 1'b1;
            redirect_pending_next = 1'b1;
          end else begin
            res[n[0]] = '{has_char: 1'b1, char_out: c, token_end: 1'b1,
                          line_done: 1'b0, last: 1'b0};
            token_open_next      = 1'b0;
            token_has_chars_next = 1'b0;
          end
          n = n + 2'd1;
        end else begin
          res[n[0]] = '{has_char: 1'b1, char_out: c, token_end: 1'b0,
                        line_done: 1'b0, last: 1'b0};
          n = n + 2'd1;
          token_open_next      = 1'b1;
          token_has_chars_next = 1'b1;
        end
      end

      // mark the final beat of this item
      if (n == 2'd2) begin
        res[1].last = 1'b1;
      end else if (n == 2'd1) begin
        res[0].last = 1'b1;
      end
    end
  end

  assign q_push        = accept && (n != 2'd0);
  assign q_entry.two    = (n == 2'd2);
  assign q_entry.first  = res[0];
  assign q_entry.second = res[1];

  // tokeniser state
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_kind       <= slt_pkg::QK_NONE;
      escape_pending   <= 1'b0;
      token_open       <= 1'b0;
      token_has_chars  <= 1'b0;
      in_comment       <= 1'b0;
      redirect_pending <= 1'b0;
    end else if (accept) begin
      quote_kind       <= quote_kind_next;
      escape_pending   <= escape_pending_next;
      token_open       <= token_open_next;
      token_has_chars  <= token_has_chars_next;
      in_comment       <= in_comment_next;
      redirect_pending <= redirect_pending_next;
    end
  end

endmodule

/* rtl/slt_queue.sv */
// ----------------------------------------------------------------------------
// slt_queue: entry queue
// Short first-in first-out queue of result entries between the classifier
// and the output sequencer, so each side can stall on its own.
// ----------------------------------------------------------------------------
module slt_queue #(
  parameter int DEPTH = slt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  slt_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output slt_pkg::entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  slt_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/slt_back.sv */
// ----------------------------------------------------------------------------
// slt_back: output sequencer
// Unpacks each queue entry into one or two result beats and drives them
// from an output register.
// ----------------------------------------------------------------------------
module slt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  slt_pkg::entry_t  q_head,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_ready,
  output slt_pkg::result_t result
);

  logic phase;
  logic load;

  // output register free, or its beat leaves this cycle
  assign load  = !result_valid || result_ready;
  assign q_pop = load && !q_empty && (phase || !q_head.two);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase        <= 1'b0;
    end else if (load) begin
      result_valid <= !q_empty;
      if (!q_empty) begin
        phase <= q_head.two && !phase;
      end
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      result <= phase ? q_head.second : q_head.first;
    end
  end

endmodule

/* rtl/shell_line_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// shell_line_tokenizer_unit: command line tokeniser
// Splits a command line, one byte per beat, into token characters and token
// end marks, handling quotes, escapes, operators and comments.
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_ready      command, byte_in
//   result   out        result_valid / result_ready  has_char, char_out,
//                                                    token_end, line_done, last
//
// One item is taken per cycle while the entry queue has room; it gives zero,
// one or two result beats. The output register sends one beat per cycle
// while result_ready is high, the beats of a two-beat item one after the other.
// An item's first beat goes through the entry queue and then the output register.
// Synchronous reset clears the tokeniser state, the queue and the output.
// A stalled result side fills the queue (QUEUE_DEPTH entries) before
// item_ready drops.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_unit #(
  parameter int QUEUE_DEPTH = slt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  slt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output slt_pkg::result_t result
);

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  slt_pkg::entry_t q_entry;
  slt_pkg::entry_t q_head;

  // classifier
  slt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // entry queue
  slt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // output sequencer
  slt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // no pop from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // an end-of-line beat is always the last of its item
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.line_done |-> result.last && !result.has_char)
    else $error("line_done beat not last or carries a character");

  // a beat without a character carries a zero code
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_char |-> result.char_out == 8'h00)
    else $error("char_out set on a beat without a character");

  // a single-beat entry leaves the queue in the cycle it is loaded
  assert property (@(posedge clk) disable iff (rst)
    !q_empty && !q_head.two && (!result_valid || result_ready) |-> q_pop)
    else $error("single-beat entry not popped on load");
`endif

endmodule
